// File: src/bmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_pkg
// shared types, constants and calibration defaults of barometer compensation
// ----------------------------------------------------------------------------
package bmpc_pkg;

  localparam int RawW  = 16;
  localparam int TempW = 13;
  localparam int PresW = 18;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AC1   = 8'd0,
    REG_AC2   = 8'd1,
    REG_AC3   = 8'd2,
    REG_AC4   = 8'd3,
    REG_AC5   = 8'd4,
    REG_AC6   = 8'd5,
    REG_BPAIR = 8'd6,
    REG_MCMD  = 8'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  localparam logic [15:0] RstAc1   = 16'd408;
  localparam logic [15:0] RstAc2   = 16'hFFB8;
  localparam logic [15:0] RstAc3   = 16'hC7D1;
  localparam logic [15:0] RstAc4   = 16'd32741;
  localparam logic [15:0] RstAc5   = 16'd32757;
  localparam logic [15:0] RstAc6   = 16'd23153;
  localparam logic [31:0] RstBPair = 32'h182E0004;
  localparam logic [31:0] RstMcMd  = 32'hDDF90B34;

  localparam int TempMin  = -4096;
  localparam int TempMax  = 4095;
  localparam int PresMax  = 262143;
  localparam int PLimit   = 1048576;
  localparam int B6Offset = 4000;
  localparam int B7Scale  = 50000;
  localparam int TermBias = 32768;
  localparam int CorrSq   = 3038;
  localparam int CorrLin  = 7357;
  localparam int CorrOff  = 3791;

  localparam int TdivNumW = 27;
  localparam int TdivDenW = 19;
  localparam int TdivQuoW = 27;
  localparam int PdivNumW = 64;
  localparam int PdivDenW = 46;
  localparam int PdivQuoW = 22;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  typedef struct packed {
    logic signed [18:0] x1;
    logic [RawW-1:0]    up;
    logic               dz;
    logic               neg;
  } tdiv_sb_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic                    tsat;
    logic                    dz;
    logic                    bad;
    logic                    neg;
    logic                    mode;
    logic                    ovf;
  } pdiv_sb_t;

endpackage

// File: src/bmpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_div
// pipelined restoring divider, one quotient bit per stage, unsigned operands
// ----------------------------------------------------------------------------
module bmpc_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 19,
  parameter int QUO_W = 27,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output logic [SB_W-1:0]  out_sb
);

  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic             vld_r [QUO_W];
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [SB_W-1:0]  sb_r  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic             v_in;
    logic [NUM_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QUO_W-1:0] q_in;
    logic [SB_W-1:0]  s_in;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_w;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = in_sb;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
      assign s_in = sb_r[k-1];
    end

    assign trial = CMP_W'(d_in) << SH;
    assign rem_w = CMP_W'(r_in);
    assign ge    = rem_w >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? NUM_W'(rem_w - trial) : r_in;
        den_r[k] <= d_in;
        quo_r[k] <= (q_in << 1) | QUO_W'(ge);
        sb_r[k]  <= s_in;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign quo       = quo_r[QUO_W-1];
  assign out_sb    = sb_r[QUO_W-1];

endmodule

// File: src/bmpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_front
// temperature path: x1 product, x2 division and b5
// ----------------------------------------------------------------------------
module bmpc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  bmpc_pkg::cal_t               cal,
  input  logic                         in_valid,
  input  logic [bmpc_pkg::RawW-1:0]    in_ut,
  input  logic [bmpc_pkg::RawW-1:0]    in_up,
  output logic                         out_valid,
  output logic signed [27:0]           out_b5,
  output logic [bmpc_pkg::RawW-1:0]    out_up,
  output logic                         out_dz
);

  // stage 1: (ut - ac6) * ac5
  logic signed [16:0] diff;
  logic               v1;
  logic signed [33:0] prod1;
  logic [bmpc_pkg::RawW-1:0] up1;

  assign diff = $signed({1'b0, in_ut}) - $signed({1'b0, cal.ac6});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= diff * $signed({1'b0, cal.ac5});
      up1   <= in_up;
    end
  end

  // stage 2: divider operands
  logic signed [18:0] x1;
  logic signed [19:0] den;
  logic signed [26:0] num;
  logic [26:0]        num_mag;
  logic [19:0]        den_neg;
  logic [18:0]        den_mag;
  logic               dz;
  logic               v2;
  logic [bmpc_pkg::TdivNumW-1:0] num2;
  logic [bmpc_pkg::TdivDenW-1:0] den2;
  bmpc_pkg::tdiv_sb_t sb2;

  assign x1      = $signed(prod1[33:15]);
  assign den     = {x1[18], x1} + {{4{cal.md[15]}}, cal.md};
  assign num     = {cal.mc, 11'b0};
  assign num_mag = num[26] ? 27'(-num) : 27'(num);
  assign den_neg = 20'(-den);
  assign dz      = (den == 20'sd0);
  assign den_mag = dz ? 19'd1 : (den[19] ? den_neg[18:0] : den[18:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2    <= num_mag;
      den2    <= den_mag;
      sb2.x1  <= x1;
      sb2.up  <= up1;
      sb2.dz  <= dz;
      sb2.neg <= num[26] ^ den[19];
    end
  end

  logic                          dv;
  logic [bmpc_pkg::TdivQuoW-1:0] dq;
  bmpc_pkg::tdiv_sb_t            dsb;

  bmpc_div #(
    .NUM_W (bmpc_pkg::TdivNumW),
    .DEN_W (bmpc_pkg::TdivDenW),
    .QUO_W (bmpc_pkg::TdivQuoW),
    .SB_W  ($bits(bmpc_pkg::tdiv_sb_t))
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .num       (num2),
    .den       (den2),
    .in_sb     (sb2),
    .out_valid (dv),
    .quo       (dq),
    .out_sb    (dsb)
  );

  // stage 3: b5 = x1 + x2
  logic signed [27:0] x2;

  assign x2 = dsb.neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_b5 <= x2 + {{9{dsb.x1[18]}}, dsb.x1};
      out_up <= dsb.up;
      out_dz <= dsb.dz;
    end
  end

endmodule

// File: src/bmpc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_scale
// temperature result, b3, b4 and b7 terms, pressure divider operands
// ----------------------------------------------------------------------------
module bmpc_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  bmpc_pkg::cal_t                cal,
  input  logic                          in_valid,
  input  logic signed [27:0]            in_b5,
  input  logic [bmpc_pkg::RawW-1:0]     in_up,
  input  logic                          in_dz,
  output logic                          out_valid,
  output logic [bmpc_pkg::PdivNumW-1:0] out_num,
  output logic [bmpc_pkg::PdivDenW-1:0] out_den,
  output bmpc_pkg::pdiv_sb_t            out_sb
);

  // stage 1: temperature, b6 products
  logic signed [28:0] tsum;
  logic signed [24:0] tfull;
  logic signed [27:0] b6;
  logic signed [bmpc_pkg::TempW-1:0] tval;
  logic               tsat;

  assign tsum  = {in_b5[27], in_b5} + 29'sd8;
  assign tfull = $signed(tsum[28:4]);
  assign b6    = in_b5 - 28'(bmpc_pkg::B6Offset);

  always_comb begin
    tval = tfull[bmpc_pkg::TempW-1:0];
    tsat = 1'b0;
    if (tfull < 25'(bmpc_pkg::TempMin)) begin
      tval = bmpc_pkg::TempW'(bmpc_pkg::TempMin);
      tsat = 1'b1;
    end else if (tfull > 25'(bmpc_pkg::TempMax)) begin
      tval = bmpc_pkg::TempW'(bmpc_pkg::TempMax);
      tsat = 1'b1;
    end
  end

  logic v1, dz1, ts1;
  logic signed [bmpc_pkg::TempW-1:0] t1;
  logic [bmpc_pkg::RawW-1:0] up1;
  logic signed [55:0] sqp1;
  logic signed [43:0] a2p1, a3p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz1  <= in_dz;
      ts1  <= tsat;
      t1   <= tval;
      up1  <= in_up;
      sqp1 <= b6 * b6;
      a2p1 <= cal.ac2 * b6;
      a3p1 <= cal.ac3 * b6;
    end
  end

  // stage 2: b2 and b1 times b6 squared
  logic signed [44:0] sq;
  logic v2, dz2, ts2;
  logic signed [bmpc_pkg::TempW-1:0] t2;
  logic [bmpc_pkg::RawW-1:0] up2;
  logic signed [60:0] b2sq2, b1sq2;
  logic signed [43:0] a2p2, a3p2;

  assign sq = $signed({1'b0, sqp1[55:12]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz2   <= dz1;
      ts2   <= ts1;
      t2    <= t1;
      up2   <= up1;
      b2sq2 <= cal.b2 * sq;
      b1sq2 <= cal.b1 * sq;
      a2p2  <= a2p1;
      a3p2  <= a3p1;
    end
  end

  // stage 3: b3 and pressure scale term
  logic signed [50:0] x3a;
  logic signed [51:0] b3sum;
  logic signed [46:0] x3bsum;
  logic signed [45:0] term;
  logic v3, dz3, ts3;
  logic signed [bmpc_pkg::TempW-1:0] t3;
  logic [bmpc_pkg::RawW-1:0] up3;
  logic signed [49:0] b3_3;
  logic signed [45:0] term3;

  assign x3a    = $signed({b2sq2[60], b2sq2[60:11]})
                + $signed({{18{a2p2[43]}}, a2p2[43:11]});
  assign b3sum  = $signed({{34{cal.ac1[15]}}, cal.ac1, 2'b00})
                + $signed({x3a[50], x3a}) + 52'sd2;
  assign x3bsum = $signed({{16{a3p2[43]}}, a3p2[43:13]})
                + $signed({{2{b1sq2[60]}}, b1sq2[60:16]}) + 47'sd2;
  assign term   = $signed({x3bsum[46], x3bsum[46:2]}) + 46'(bmpc_pkg::TermBias);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz3   <= dz2;
      ts3   <= ts2;
      t3    <= t2;
      up3   <= up2;
      b3_3  <= $signed(b3sum[51:2]);
      term3 <= term;
    end
  end

  // stage 4: b4 product and b7
  logic signed [50:0] upd;
  logic signed [67:0] b7full;
  logic v4, dz4, ts4, bad4;
  logic signed [bmpc_pkg::TempW-1:0] t4;
  logic [60:0] b4p4;
  logic signed [63:0] b7_4;

  assign upd    = $signed({35'b0, up3}) - $signed({b3_3[49], b3_3});
  assign b7full = upd * $signed(17'(bmpc_pkg::B7Scale));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz4  <= dz3;
      ts4  <= ts3;
      t4   <= t3;
      bad4 <= (term3 <= 46'sd0);
      b4p4 <= cal.ac4 * term3[44:0];
      b7_4 <= $signed(b7full[63:0]);
    end
  end

  // stage 5: pressure divider operands and range check
  logic [45:0]        b4;
  logic               bad5;
  logic               mode;
  logic signed [63:0] n;
  logic [63:0]        nmag;
  logic [45:0]        den5;
  logic               ovf;

  assign b4   = b4p4[60:15];
  assign bad5 = bad4 || (b4 == 46'd0);
  assign mode = (b7_4 >= 64'sh80000000);
  assign n    = mode ? b7_4 : (b7_4 <<< 1);
  assign nmag = n[63] ? 64'(-n) : 64'(n);
  assign den5 = bad5 ? 46'd1 : b4;
  assign ovf  = {4'b0, nmag} >= {den5, 22'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num     <= ovf ? 64'd0 : nmag;
      out_den     <= den5;
      out_sb.temp <= t4;
      out_sb.tsat <= ts4;
      out_sb.dz   <= dz4;
      out_sb.bad  <= bad5;
      out_sb.neg  <= n[63];
      out_sb.mode <= mode;
      out_sb.ovf  <= ovf;
    end
  end

endmodule

// File: src/bmpc_pres.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_pres
// pressure division, final correction polynomial and output saturation
// ----------------------------------------------------------------------------
module bmpc_pres (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [bmpc_pkg::PdivNumW-1:0]   in_num,
  input  logic [bmpc_pkg::PdivDenW-1:0]   in_den,
  input  bmpc_pkg::pdiv_sb_t              in_sb,
  output logic                            out_valid,
  output logic signed [bmpc_pkg::TempW-1:0] out_temp,
  output logic [bmpc_pkg::PresW-1:0]      out_pres,
  output bmpc_pkg::status_t               out_status
);

  logic                          dv;
  logic [bmpc_pkg::PdivQuoW-1:0] dq;
  bmpc_pkg::pdiv_sb_t            dsb;

  bmpc_div #(
    .NUM_W (bmpc_pkg::PdivNumW),
    .DEN_W (bmpc_pkg::PdivDenW),
    .QUO_W (bmpc_pkg::PdivQuoW),
    .SB_W  ($bits(bmpc_pkg::pdiv_sb_t))
  ) u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .num       (in_num),
    .den       (in_den),
    .in_sb     (in_sb),
    .out_valid (dv),
    .quo       (dq),
    .out_sb    (dsb)
  );

  // stage 1: range of p, squared and linear terms
  logic [22:0] pmag;
  logic        pneg, pbig;
  logic [20:0] p;

  assign pmag = dsb.mode ? {dq, 1'b0} : {1'b0, dq};
  assign pneg = dsb.neg && (dsb.ovf || (pmag != 23'd0));
  assign pbig = !dsb.neg && (dsb.ovf || (pmag > 23'(bmpc_pkg::PLimit)));
  assign p    = pmag[20:0];

  logic v1, neg1, big1;
  logic [20:0] p1;
  logic [25:0] qq1;
  logic [33:0] c2p1;
  bmpc_pkg::pdiv_sb_t sb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= pneg;
      big1 <= pbig;
      p1   <= p;
      qq1  <= p[20:8] * p[20:8];
      c2p1 <= p * 13'(bmpc_pkg::CorrLin);
      sb1  <= dsb;
    end
  end

  // stage 2: squared term times its coefficient
  logic v2, neg2, big2;
  logic [20:0] p2;
  logic [37:0] c1_2;
  logic [33:0] c2p2;
  bmpc_pkg::pdiv_sb_t sb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      big2 <= big1;
      p2   <= p1;
      c1_2 <= qq1 * 12'(bmpc_pkg::CorrSq);
      c2p2 <= c2p1;
      sb2  <= sb1;
    end
  end

  // final sum and saturation
  logic signed [34:0] c2n;
  logic signed [23:0] csum;
  logic signed [19:0] corr;
  logic signed [22:0] pfull;
  logic [bmpc_pkg::PresW-1:0] pres;
  logic psat;

  assign c2n   = -$signed({1'b0, c2p2});
  assign csum  = $signed({2'b00, c1_2[37:16]})
               + $signed({{5{c2n[34]}}, c2n[34:16]})
               + 24'(bmpc_pkg::CorrOff);
  assign corr  = $signed(csum[23:4]);
  assign pfull = $signed({2'b00, p2}) + $signed({{3{corr[19]}}, corr});

  always_comb begin
    pres = pfull[bmpc_pkg::PresW-1:0];
    psat = 1'b0;
    if (neg2) begin
      pres = '0;
      psat = 1'b1;
    end else if (big2) begin
      pres = bmpc_pkg::PresW'(bmpc_pkg::PresMax);
      psat = 1'b1;
    end else if (pfull < 23'sd0) begin
      pres = '0;
      psat = 1'b1;
    end else if (pfull > 23'(bmpc_pkg::PresMax)) begin
      pres = bmpc_pkg::PresW'(bmpc_pkg::PresMax);
      psat = 1'b1;
    end
  end

  assign out_valid = v2;

  always_comb begin
    out_temp   = sb2.temp;
    out_pres   = pres;
    out_status = bmpc_pkg::ST_OK;
    if (sb2.dz) begin
      out_temp   = '0;
      out_pres   = '0;
      out_status = bmpc_pkg::ST_DIVZERO;
    end else if (sb2.bad) begin
      out_pres   = '0;
      out_status = bmpc_pkg::ST_DIVZERO;
    end else if (sb2.tsat || psat) begin
      out_status = bmpc_pkg::ST_SAT;
    end
  end

endmodule

// File: src/barometer_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_compensation
// integer temperature and pressure compensation of a barometric sensor
// ----------------------------------------------------------------------------
// s_tdata carries one raw temperature / pressure pair per item; m_tdata returns
// temperature in tenths of a degree and pressure in pascals, m_tuser a status
// (ok, saturated, zero divisor). the cfg channel writes the eight calibration
// registers and is always ready; write only while no item is in flight.
// two restoring dividers of 27 and 22 stages (one quotient bit per stage) and the
// multiplier and correction stages lie between input and output. one item is
// accepted every cycle while the output is not stalled.
// the whole pipeline advances only while the output register is empty or
// being taken, so a stalled receiver holds every item in place and s_tready
// drops; nothing is lost or repeated. reset empties the pipeline and loads
// the default calibration words.
// ----------------------------------------------------------------------------
module barometer_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // raw_temperature, raw_pressure
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // temperature_tenths, pressure_pa, zero pad
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bmpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bmpc_pkg::CfgDataW-1:0] cfg_data
);

  logic en;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // calibration registers
  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
  logic [31:0] bpair, mcmd;
  bmpc_pkg::cal_t cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1   <= bmpc_pkg::RstAc1;
      ac2   <= bmpc_pkg::RstAc2;
      ac3   <= bmpc_pkg::RstAc3;
      ac4   <= bmpc_pkg::RstAc4;
      ac5   <= bmpc_pkg::RstAc5;
      ac6   <= bmpc_pkg::RstAc6;
      bpair <= bmpc_pkg::RstBPair;
      mcmd  <= bmpc_pkg::RstMcMd;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmpc_pkg::REG_AC1:   ac1   <= cfg_data[15:0];
        bmpc_pkg::REG_AC2:   ac2   <= cfg_data[15:0];
        bmpc_pkg::REG_AC3:   ac3   <= cfg_data[15:0];
        bmpc_pkg::REG_AC4:   ac4   <= cfg_data[15:0];
        bmpc_pkg::REG_AC5:   ac5   <= cfg_data[15:0];
        bmpc_pkg::REG_AC6:   ac6   <= cfg_data[15:0];
        bmpc_pkg::REG_BPAIR: bpair <= cfg_data;
        bmpc_pkg::REG_MCMD:  mcmd  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cal.ac1 = $signed(ac1);
  assign cal.ac2 = $signed(ac2);
  assign cal.ac3 = $signed(ac3);
  assign cal.ac4 = ac4;
  assign cal.ac5 = ac5;
  assign cal.ac6 = ac6;
  assign cal.b1  = $signed(bpair[31:16]);
  assign cal.b2  = $signed(bpair[15:0]);
  assign cal.mc  = $signed(mcmd[31:16]);
  assign cal.md  = $signed(mcmd[15:0]);

  logic               fv, fdz;
  logic signed [27:0] fb5;
  logic [15:0]        fup;

  bmpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cal       (cal),
    .in_valid  (s_tvalid),
    .in_ut     (s_tdata[15:0]),
    .in_up     (s_tdata[31:16]),
    .out_valid (fv),
    .out_b5    (fb5),
    .out_up    (fup),
    .out_dz    (fdz)
  );

  logic                          sv;
  logic [bmpc_pkg::PdivNumW-1:0] snum;
  logic [bmpc_pkg::PdivDenW-1:0] sden;
  bmpc_pkg::pdiv_sb_t            ssb;

  bmpc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cal       (cal),
    .in_valid  (fv),
    .in_b5     (fb5),
    .in_up     (fup),
    .in_dz     (fdz),
    .out_valid (sv),
    .out_num   (snum),
    .out_den   (sden),
    .out_sb    (ssb)
  );

  logic                              pv;
  logic signed [bmpc_pkg::TempW-1:0] ptemp;
  logic [bmpc_pkg::PresW-1:0]        ppres;
  bmpc_pkg::status_t                 pstat;

  bmpc_pres u_pres (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sv),
    .in_num     (snum),
    .in_den     (sden),
    .in_sb      (ssb),
    .out_valid  (pv),
    .out_temp   (ptemp),
    .out_pres   (ppres),
    .out_status (pstat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, ppres, ptemp};
      m_tuser <= pstat;
    end
  end

endmodule

// File: src/bmpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpc_checker
// port level checks of barometer compensation, bound to the top level
// ----------------------------------------------------------------------------
module bmpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        cfg_ready
);

  // output held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed under stall");

  // input side free whenever the receiver takes
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // no status code beyond zero divisor
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == bmpc_pkg::ST_OK) || (m_tuser == bmpc_pkg::ST_SAT)
                 || (m_tuser == bmpc_pkg::ST_DIVZERO))
    else $error("bad status code");

  // no output item and cfg channel ready after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && cfg_ready)
    else $error("item out right after reset");

endmodule

bind barometer_compensation bmpc_checker u_bmpc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
